/* sv/binary_min_heap_priority_queue_macros.svh */
// Assertion macros for the binary min-heap priority queue.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define BMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BMH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMH_ASSERT(lbl, prop, msg)
`define BMH_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* sv/bmh_pkg.sv */
// Types and constants shared by the heap queue modules.
package bmh_pkg;
  localparam int DEPTH        = 256;
  localparam int ADDR_BITS    = $clog2(DEPTH);
  localparam int CNT_BITS     = ADDR_BITS + 1;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 16;
  localparam int SLOT_BITS    = 8;
  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

  typedef enum logic [1:0] {
    CMD_INSERT, CMD_EXTRACT, CMD_CHANGE, CMD_FIND
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK, ST_EMPTY, ST_FULL, ST_RANGE, ST_NOTFOUND
  } status_t;

  typedef struct packed {
    cmd_t                           command;
    logic signed [KEY_BITS-1:0]     key;
    logic        [PAYLOAD_BITS-1:0] payload;
    logic        [SLOT_BITS-1:0]    slot;
  } in_item_t;

  typedef struct packed {
    status_t                        status;
    logic signed [KEY_BITS-1:0]     out_key;
    logic        [PAYLOAD_BITS-1:0] out_payload;
    logic        [SLOT_BITS-1:0]    found_slot;
  } out_item_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0]     key;
    logic        [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_BITS-1:0] ra;
    logic [ADDR_BITS-1:0] rb;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wa;
    entry_t               wd;
  } mem_req_t;
endpackage

/* sv/bmh_ram.sv */
// Generic RAM: one write port, two registered read ports.
module bmh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH_P = 256,
  localparam int AW = $clog2(DEPTH_P)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    ra,
  input  logic [AW-1:0]    rb,
  output logic [WIDTH-1:0] qa,
  output logic [WIDTH-1:0] qb,
  input  logic             wr_en,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd
);
  logic [WIDTH-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      qa <= mem[ra];
      qb <= mem[rb];
    end
  end
endmodule

/* sv/bmh_core.sv */
// Command sequencer with one shared key comparator; walks the heap in memory.
`include "binary_min_heap_priority_queue_macros.svh"
module bmh_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bmh_pkg::in_item_t   in_item,
  output logic                res_valid,
  input  logic                res_free,
  output bmh_pkg::out_item_t  res,
  output bmh_pkg::mem_req_t   mem,
  input  bmh_pkg::entry_t     qa,
  input  bmh_pkg::entry_t     qb
);
  typedef enum logic [3:0] {
    S_IDLE, S_SU_RD, S_SU_CMP, S_SD_RD, S_SD_L, S_SD_R, S_EX_RD, S_EX_CAP,
    S_CH_RD, S_CH_CMP, S_FD_RD, S_FD_CMP, S_FIN
  } state_t;

  state_t                                  state;
  logic [bmh_pkg::CNT_BITS-1:0]            count;
  logic [bmh_pkg::ADDR_BITS-1:0]           pos;
  logic [bmh_pkg::CNT_BITS-1:0]            idx;
  bmh_pkg::entry_t                         ent;
  bmh_pkg::in_item_t                       req;
  logic                                    best_sel;
  logic signed [bmh_pkg::KEY_BITS-1:0]     best_key;

  logic [bmh_pkg::CNT_BITS-1:0]            lc;
  logic [bmh_pkg::CNT_BITS:0]              rc;
  logic [bmh_pkg::ADDR_BITS-1:0]           parent;
  logic                                    lc_in, rc_in, pos_in;
  logic signed [bmh_pkg::KEY_BITS-1:0]     cmp_a, cmp_b;
  logic                                    lt;
  logic                                    pick_r, best_now;

  assign lc     = {pos, 1'b1};
  assign rc     = {1'b0, pos, 1'b0} + (bmh_pkg::CNT_BITS+1)'(2);
  assign parent = (pos - 1'b1) >> 1;
  assign lc_in  = lc < count;
  assign rc_in  = rc < {1'b0, count};
  assign pos_in = {1'b0, pos} < count;

  // shared comparator: cmp_a < cmp_b, signed
  always_comb begin
    case (state)
      S_SD_L:   begin cmp_a = qa.key; cmp_b = ent.key;  end
      S_SD_R:   begin cmp_a = qb.key; cmp_b = best_key; end
      S_CH_CMP: begin cmp_a = qa.key; cmp_b = req.key;  end
      default:  begin cmp_a = ent.key; cmp_b = qa.key;  end
    endcase
  end
  assign lt = cmp_a < cmp_b;

  assign pick_r   = rc_in && lt;
  assign best_now = best_sel || pick_r;

  always_comb begin
    mem = '0;
    unique case (state)
      S_SU_RD: begin
        if (pos == '0) begin
          mem.wr_en = 1'b1;
          mem.wd    = ent;
        end else begin
          mem.rd_en = 1'b1;
          mem.ra    = parent;
        end
      end
      S_SU_CMP: begin
        mem.wr_en = 1'b1;
        mem.wa    = pos;
        mem.wd    = lt ? qa : ent;
      end
      S_SD_RD: begin
        mem.ra = lc[bmh_pkg::ADDR_BITS-1:0];
        mem.rb = rc[bmh_pkg::ADDR_BITS-1:0];
        mem.rd_en = lc_in;
        mem.wr_en = !lc_in && pos_in;
        mem.wa    = pos;
        mem.wd    = ent;
      end
      S_SD_L: begin
        mem.ra = lc[bmh_pkg::ADDR_BITS-1:0];
        mem.rb = rc[bmh_pkg::ADDR_BITS-1:0];
      end
      S_SD_R: begin
        mem.wr_en = 1'b1;
        mem.wa    = pos;
        mem.wd    = pick_r ? qb : (best_sel ? qa : ent);
      end
      S_EX_RD: begin
        mem.rd_en = 1'b1;
        mem.rb    = bmh_pkg::ADDR_BITS'(count - 1'b1);
      end
      S_CH_RD: begin
        mem.rd_en = 1'b1;
        mem.ra    = req.slot;
      end
      S_FD_RD: begin
        mem.rd_en = idx < count;
        mem.ra    = idx[bmh_pkg::ADDR_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  assign in_stall  = state != S_IDLE;
  assign res_valid = (state == S_FIN) && res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_item;
            unique case (in_item.command)
              bmh_pkg::CMD_INSERT: begin
                if (count == bmh_pkg::FULL_COUNT) begin
                  res   <= '{status: bmh_pkg::ST_FULL, out_key: '0,
                             out_payload: '0, found_slot: '0};
                  state <= S_FIN;
                end else begin
                  res   <= '0;
                  ent   <= '{key: in_item.key, payload: in_item.payload};
                  pos   <= count[bmh_pkg::ADDR_BITS-1:0];
                  count <= count + 1'b1;
                  state <= S_SU_RD;
                end
              end
              bmh_pkg::CMD_EXTRACT: begin
                if (count == '0) begin
                  res   <= '{status: bmh_pkg::ST_EMPTY, out_key: '0,
                             out_payload: '0, found_slot: '0};
                  state <= S_FIN;
                end else begin
                  res   <= '0;
                  state <= S_EX_RD;
                end
              end
              bmh_pkg::CMD_CHANGE: begin
                if (bmh_pkg::CNT_BITS'(in_item.slot) >= count) begin
                  res   <= '{status: bmh_pkg::ST_RANGE, out_key: '0,
                             out_payload: '0, found_slot: '0};
                  state <= S_FIN;
                end else begin
                  res   <= '0;
                  state <= S_CH_RD;
                end
              end
              default: begin
                res   <= '0;
                idx   <= '0;
                state <= S_FD_RD;
              end
            endcase
          end
        end
        S_SU_RD:  state <= (pos == '0) ? S_FIN : S_SU_CMP;
        S_SU_CMP: begin
          if (lt) begin
            pos   <= parent;
            state <= S_SU_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_SD_RD:  state <= lc_in ? S_SD_L : S_FIN;
        S_SD_L: begin
          best_sel <= lt;
          best_key <= lt ? qa.key : ent.key;
          state    <= S_SD_R;
        end
        S_SD_R: begin
          if (best_now) begin
            pos   <= pick_r ? rc[bmh_pkg::ADDR_BITS-1:0] : lc[bmh_pkg::ADDR_BITS-1:0];
            state <= S_SD_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_EX_RD:  state <= S_EX_CAP;
        S_EX_CAP: begin
          res   <= '{status: bmh_pkg::ST_OK, out_key: qa.key,
                     out_payload: qa.payload, found_slot: '0};
          ent   <= qb;
          count <= count - 1'b1;
          pos   <= '0;
          state <= S_SD_RD;
        end
        S_CH_RD:  state <= S_CH_CMP;
        S_CH_CMP: begin
          ent <= '{key: req.key, payload: qa.payload};
          pos <= req.slot;
          // an unchanged key stops at once in sift-up
          state <= lt ? S_SD_RD : S_SU_RD;
        end
        S_FD_RD: begin
          if (idx < count) begin
            state <= S_FD_CMP;
          end else begin
            res.status <= bmh_pkg::ST_NOTFOUND;
            state      <= S_FIN;
          end
        end
        S_FD_CMP: begin
          if (qa.payload == req.payload) begin
            res.found_slot <= idx[bmh_pkg::SLOT_BITS-1:0];
            state          <= S_FIN;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_FD_RD;
          end
        end
        S_FIN: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BMH_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && count == '0), "reset not idle")
  `BMH_ASSERT(a_count_range, count <= bmh_pkg::FULL_COUNT, "heap count above depth")
  `BMH_ASSERT(a_wr_in_heap, mem.wr_en |-> ({1'b0, mem.wa} < count), "write beyond heap end")
  `BMH_ASSERT(a_ex_dec, (state == S_EX_CAP) |=> (count == $past(count) - 1'b1), "extract count")
  `BMH_ASSERT(a_res_idle, res_valid |=> (state == S_IDLE), "result beat not followed by idle")
endmodule

/* sv/binary_min_heap_priority_queue.sv */
// Insert sifts the new entry up level by level from the end of the heap.
// Extract reads the root and the last entry, then sifts down; error results need no memory walk.
// Change-key: the insert walk for sift-up, the extract walk for sift-down.
// Find scans the entries in order until a match; the next item is accepted once the result is taken.
// Synchronous active-high reset empties the heap; entry memory is not cleared.
module binary_min_heap_priority_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bmh_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bmh_pkg::out_item_t out_item
);
  bmh_pkg::mem_req_t  mem;
  bmh_pkg::out_item_t res;
  bmh_pkg::entry_t    qa, qb;
  logic               res_valid, res_free;
  logic [bmh_pkg::ENTRY_BITS-1:0] qa_raw, qb_raw;

  assign res_free = !out_valid || !out_stall;
  assign qa = qa_raw;
  assign qb = qb_raw;

  bmh_core u_core (
    .clk, .rst, .in_valid, .in_stall, .in_item,
    .res_valid, .res_free, .res, .mem, .qa, .qb
  );

  bmh_ram #(.WIDTH(bmh_pkg::ENTRY_BITS), .DEPTH_P(bmh_pkg::DEPTH)) u_ram (
    .clk,
    .rd_en (mem.rd_en),
    .ra    (mem.ra),
    .rb    (mem.rb),
    .qa    (qa_raw),
    .qb    (qb_raw),
    .wr_en (mem.wr_en),
    .wa    (mem.wa),
    .wd    (mem.wd)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
      out_item  <= res;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
endmodule

/* bench/binary_min_heap_priority_queue_test.sv */
// Self-checking testbench for the binary min-heap priority queue.
`timescale 1ns / 100ps

module binary_min_heap_priority_queue_test;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 1200;

  typedef struct {
    bmh_pkg::in_item_t  beat;
    logic               typed;
    bmh_pkg::out_item_t want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  bmh_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bmh_pkg::out_item_t out_item;

  bmh_pkg::entry_t    heap_model [bmh_pkg::DEPTH];
  int                 heap_size = 0;
  bmh_pkg::out_item_t pending_results [$];
  stim_row_t          directed_rows [$];
  int                 fail_count = 0;
  int                 row_fail = 0;
  int                 cycle_count = 0;

  binary_min_heap_priority_queue DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void swap_entries(int a, int b);
    bmh_pkg::entry_t t;
    t = heap_model[a];
    heap_model[a] = heap_model[b];
    heap_model[b] = t;
  endfunction

  function automatic void bubble_up(int pos);
    int up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!(heap_model[pos].key < heap_model[up].key)) break;
      swap_entries(pos, up);
      pos = up;
    end
  endfunction

  function automatic void bubble_down(int pos);
    int best;
    int lc;
    while (pos < heap_size) begin
      lc = 2 * pos + 1;
      best = pos;
      if (lc < heap_size && heap_model[lc].key < heap_model[best].key) best = lc;
      if (lc + 1 < heap_size && heap_model[lc + 1].key < heap_model[best].key)
        best = lc + 1;
      if (best == pos) break;
      swap_entries(pos, best);
      pos = best;
    end
  endfunction

  // Apply one command to the shadow heap and return the result it gives.
  function automatic bmh_pkg::out_item_t heap_result(bmh_pkg::in_item_t cmd);
    bmh_pkg::out_item_t r;
    logic signed [bmh_pkg::KEY_BITS-1:0] old_key;
    r = '0;
    r.status = bmh_pkg::ST_OK;
    case (cmd.command)
      bmh_pkg::CMD_INSERT: begin
        if (heap_size >= bmh_pkg::DEPTH) begin
          r.status = bmh_pkg::ST_FULL;
        end else begin
          heap_model[heap_size] = '{key: cmd.key, payload: cmd.payload};
          heap_size++;
          bubble_up(heap_size - 1);
        end
      end
      bmh_pkg::CMD_EXTRACT: begin
        if (heap_size == 0) begin
          r.status = bmh_pkg::ST_EMPTY;
        end else begin
          r.out_key = heap_model[0].key;
          r.out_payload = heap_model[0].payload;
          heap_model[0] = heap_model[heap_size - 1];
          heap_size--;
          bubble_down(0);
        end
      end
      bmh_pkg::CMD_CHANGE: begin
        if (int'(cmd.slot) >= heap_size) begin
          r.status = bmh_pkg::ST_RANGE;
        end else begin
          old_key = heap_model[cmd.slot].key;
          heap_model[cmd.slot].key = cmd.key;
          if (cmd.key > old_key) bubble_down(cmd.slot);
          else if (cmd.key < old_key) bubble_up(cmd.slot);
        end
      end
      default: begin
        r.status = bmh_pkg::ST_NOTFOUND;
        for (int i = 0; i < heap_size; i++) begin
          if (heap_model[i].payload == cmd.payload) begin
            r.status = bmh_pkg::ST_OK;
            r.found_slot = i[7:0];
            break;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic bmh_pkg::in_item_t make_beat(bmh_pkg::cmd_t c, int k, int p, int s);
    bmh_pkg::in_item_t b;
    b.command = c;
    b.key = k;
    b.payload = p[15:0];
    b.slot = s[7:0];
    return b;
  endfunction

  function automatic bmh_pkg::out_item_t make_result(bmh_pkg::status_t s, int k, int p,
                                                     int f);
    bmh_pkg::out_item_t r;
    r.status = s;
    r.out_key = k;
    r.out_payload = p[15:0];
    r.found_slot = f[7:0];
    return r;
  endfunction

  task automatic add_row(bmh_pkg::in_item_t b, logic typed, bmh_pkg::out_item_t w);
    stim_row_t row;
    row.beat = b;
    row.typed = typed;
    row.want = w;
    directed_rows.push_back(row);
  endtask

  // Drop valid for the gap, then hold the beat until accepted; valid stays up after.
  task automatic send_beat(bmh_pkg::in_item_t b, int gap);
    bmh_pkg::out_item_t w;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    w = heap_result(b);
    pending_results.push_back(w);
  endtask

  function automatic bmh_pkg::in_item_t random_beat();
    int r;
    int k;
    bmh_pkg::cmd_t c;
    bmh_pkg::in_item_t b;
    r = $urandom_range(0, 99);
    k = $urandom;
    if ($urandom_range(0, 3) == 0) k = $urandom_range(0, 15) - 8;
    if (heap_size > 40)
      c = (r < 25) ? bmh_pkg::CMD_INSERT : (r < 60) ? bmh_pkg::CMD_EXTRACT :
          (r < 85) ? bmh_pkg::CMD_CHANGE : bmh_pkg::CMD_FIND;
    else
      c = (r < 55) ? bmh_pkg::CMD_INSERT : (r < 70) ? bmh_pkg::CMD_EXTRACT :
          (r < 88) ? bmh_pkg::CMD_CHANGE : bmh_pkg::CMD_FIND;
    b = make_beat(c, k, $urandom, $urandom);
    if (c == bmh_pkg::CMD_CHANGE && heap_size > 0 && $urandom_range(0, 4) != 0)
      b.slot = 8'($urandom_range(0, heap_size - 1));
    if (c == bmh_pkg::CMD_FIND && heap_size > 0 && $urandom_range(0, 2) != 0)
      b.payload = heap_model[$urandom_range(0, heap_size - 1)].payload;
    return b;
  endfunction

  // Receiver: stall on its own pattern and check each result beat.
  always @(posedge clk) begin
    bmh_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: expected no beat actual %p", $realtime, out_item);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_item.status !== want.status ||
              out_item.out_key !== want.out_key ||
              out_item.out_payload !== want.out_payload ||
              out_item.found_slot !== want.found_slot) begin
            $display("%0t: expected %p actual %p", $realtime, want, out_item);
            fail_count++;
          end
        end
      end
      case ((cycle_count / 300) % 3)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("binary_min_heap_priority_queue verification failed");
      $finish;
    end
  end

  initial begin
    int burst;
    int waited;
    logic paused;
    bmh_pkg::out_item_t w;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty cases, extremes, ties, errors.
    add_row(make_beat(bmh_pkg::CMD_EXTRACT, 0, 0, 0), 1,
            make_result(bmh_pkg::ST_EMPTY, 0, 0, 0));
    add_row(make_beat(bmh_pkg::CMD_FIND, 0, 16'h0, 0), 1,
            make_result(bmh_pkg::ST_NOTFOUND, 0, 0, 0));
    add_row(make_beat(bmh_pkg::CMD_CHANGE, 5, 0, 0), 1,
            make_result(bmh_pkg::ST_RANGE, 0, 0, 0));
    add_row(make_beat(bmh_pkg::CMD_INSERT, 32'h7fffffff, 16'hffff, 8'hff), 1,
            make_result(bmh_pkg::ST_OK, 0, 0, 0));
    add_row(make_beat(bmh_pkg::CMD_INSERT, 32'h80000000, 16'h0000, 0), 1,
            make_result(bmh_pkg::ST_OK, 0, 0, 0));
    add_row(make_beat(bmh_pkg::CMD_INSERT, 7, 16'h1111, 0), 0, '0);
    add_row(make_beat(bmh_pkg::CMD_INSERT, 7, 16'h2222, 0), 0, '0);
    add_row(make_beat(bmh_pkg::CMD_INSERT, -1, 16'h3333, 0), 0, '0);
    add_row(make_beat(bmh_pkg::CMD_FIND, 0, 16'hffff, 0), 0, '0);
    add_row(make_beat(bmh_pkg::CMD_FIND, 0, 16'h2222, 0), 0, '0);
    add_row(make_beat(bmh_pkg::CMD_CHANGE, 7, 0, 2), 0, '0);
    add_row(make_beat(bmh_pkg::CMD_CHANGE, 32'h80000000, 0, 3), 0, '0);
    add_row(make_beat(bmh_pkg::CMD_CHANGE, 32'h7fffffff, 0, 0), 0, '0);
    add_row(make_beat(bmh_pkg::CMD_CHANGE, 0, 0, 8'hff), 1,
            make_result(bmh_pkg::ST_RANGE, 0, 0, 0));
    add_row(make_beat(bmh_pkg::CMD_FIND, 0, 16'h5a5a, 0), 1,
            make_result(bmh_pkg::ST_NOTFOUND, 0, 0, 0));
    for (int i = 0; i < 6; i++) add_row(make_beat(bmh_pkg::CMD_EXTRACT, 0, 0, 0), 0, '0);
    add_row(make_beat(bmh_pkg::CMD_EXTRACT, 0, 0, 0), 1,
            make_result(bmh_pkg::ST_EMPTY, 0, 0, 0));

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, $urandom_range(0, 2));
      if (directed_rows[i].typed) begin
        w = pending_results[$];
        if (w !== directed_rows[i].want) begin
          $display("%0t: row %0d expected %p actual %p", $realtime, i,
                   directed_rows[i].want, w);
          row_fail++;
        end
      end
    end

    // Fill to full, overflow twice, touch the last slot, then drain part of it.
    for (int i = 0; i < bmh_pkg::DEPTH + 2; i++)
      send_beat(make_beat(bmh_pkg::CMD_INSERT, $urandom_range(0, 63) - 32, $urandom, 0),
                (i % 16 == 0) ? $urandom_range(0, 4) : 0);
    send_beat(make_beat(bmh_pkg::CMD_CHANGE, -100, 0, 255), 0);
    send_beat(make_beat(bmh_pkg::CMD_FIND, 0, heap_model[255].payload, 0), 0);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    for (int i = 0; i < 60; i++) send_beat(make_beat(bmh_pkg::CMD_EXTRACT, 0, 0, 0), 0);

    // Random part in bursts.
    for (int n = 0; n < 160; ) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst && n < 160; j++, n++)
        send_beat(random_beat(), (j == 0) ? $urandom_range(0, 30) : 0);
      if (!paused && n > 80) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && row_fail == 0 && pending_results.size() == 0) begin
      $display("binary_min_heap_priority_queue verification clean");
    end else begin
      $display("binary_min_heap_priority_queue verification failed");
    end
    $finish;
  end
endmodule
